>>> src/gmw_pkg.sv
// Shared types and constants for the Weiszfeld geometric median block.
package gmw_pkg;

	localparam int COORD_W   = 48;
	localparam int DIFF_W    = 49;
	localparam int SUMSQ_W   = 100;
	localparam int ROOT_W    = 50;
	localparam int REM_W     = 53;
	localparam int DIV_W     = 64;
	localparam int MUL_A_W   = 33;
	localparam int MUL_B_W   = 25;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int ITER_W    = 8;
	localparam int TOL_W     = 16;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CONV_TOL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEGEN_TOL = 2'd2;

	localparam logic [ITER_W-1:0] MAX_ITER_RST  = 8'd100;
	localparam logic [TOL_W-1:0]  CONV_TOL_RST  = 16'd1;
	localparam logic [TOL_W-1:0]  DEGEN_TOL_RST = 16'd1;

	// One in the 32-bit fraction format of the weights.
	localparam logic [DIV_W-1:0] WEIGHT_ONE = 64'h0000_0001_0000_0000;

	localparam logic signed [COORD_W:0] COORD_MAX_C = 49'sh0_7FFF_FFFF_FFFF;
	localparam logic signed [COORD_W:0] COORD_MIN_C = -49'sh0_8000_0000_0000;

	typedef struct packed {
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
		logic                      last_point;
	} gmw_point_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] median_x;
		logic signed [COORD_W-1:0] median_y;
		logic signed [COORD_W-1:0] median_z;
		logic [ITER_W-1:0]         iterations_done;
		logic                      set_empty;
		logic                      overflowed;
	} gmw_result_t;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_SUM_RD,
		ST_SUM_ACC,
		ST_CEN_DIV,
		ST_PASS_INIT,
		ST_PT_RD,
		ST_PT_DIFF,
		ST_SQ,
		ST_SQ_ACC,
		ST_SQRT,
		ST_WDIV,
		ST_WMUL,
		ST_WMUL_ACC,
		ST_PASS_END,
		ST_STEP_DIV,
		ST_UPDATE,
		ST_OUT
	} gmw_state_t;

	// Which partial product the shared multiplier is forming.
	typedef enum logic [2:0] {
		MK_SQ_HH,
		MK_SQ_HL,
		MK_SQ_LL,
		MK_W_LO,
		MK_W_HI
	} gmw_mul_kind_t;

endpackage

>>> src/gmw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module gmw_ram #(
	parameter int WIDTH = 144,
	parameter int DEPTH = 1024
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

>>> src/geometric_median_weiszfeld_top.sv
// Weiszfeld geometric median: loads a 3D point set, then iterates to the median.
//
// Usage: points arrive on the point channel (valid/stall), one transaction per
// point, and are written into an on-chip point memory. The transaction with
// last_point set ends the set and starts the solve; while solving, point_stall
// stays high. Points beyond MAX_POINTS are dropped and flagged in the result.
// One result transaction per set leaves on the median channel.
// Loading accepts one point per cycle. The centroid reads and sums each stored
// point, then runs three divisions. Each refinement pass reads every stored
// point and forms nine partial-product squares, a square root and a reciprocal
// in the shared serial units, then runs the step divisions and the convergence
// norm. The divider and the square-root unit are shared radix-2 serial units.
// The result sits in an output register that holds while the receiver stalls.
// The next set may load meanwhile; its median then waits, with point_stall
// high, until the previous result has been taken.
// Reset clears the point count, flags and configuration registers to their
// defaults (100 iterations, tolerances of one LSB); point memory needs no clear.
module geometric_median_weiszfeld_top #(
	parameter int MAX_POINTS = 1024
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   point_valid,
	output logic                                   point_stall,
	input  gmw_pkg::gmw_point_t                    point,
	output logic                                   median_valid,
	input  logic                                   median_stall,
	output gmw_pkg::gmw_result_t                   median,
	input  logic                                   cfg_we,
	input  logic [gmw_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [gmw_pkg::CFG_W-1:0]              cfg_data
);
	import gmw_pkg::*;

	localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int MEM_W  = 3 * COORD_W;

	function automatic logic [DIV_W-1:0] abs64(input logic signed [DIV_W-1:0] v);
		abs64 = v[DIV_W-1] ? DIV_W'(-v) : DIV_W'(v);
	endfunction

	// Control state.
	gmw_state_t           state_q, state_d;
	logic [ITER_W-1:0]    max_iter_q;
	logic [TOL_W-1:0]     conv_tol_q, degen_tol_q;
	logic [CNT_W-1:0]     count_q, idx_q;
	logic                 dropped_q;
	logic [ITER_W-1:0]    pass_q;
	logic                 conv_mode_q;
	logic [1:0]           axis_q, part_q;
	logic [6:0]           div_cnt_q;
	logic [5:0]           sq_cnt_q;
	logic                 mul_v_s1;
	logic                 out_valid_q;

	// Datapath registers.
	logic signed [DIV_W-1:0]   sum_x_q, sum_y_q, sum_z_q;
	logic signed [COORD_W-1:0] est_x_q, est_y_q, est_z_q;
	logic [DIFF_W-1:0]         mag_x_q, mag_y_q, mag_z_q;
	logic                      neg_x_q, neg_y_q, neg_z_q;
	logic [SUMSQ_W-1:0]        sumsq_q;
	logic [MUL_A_W-1:0]        w_q;
	logic signed [DIV_W-1:0]   ws_x_q, ws_y_q, ws_z_q;
	logic [DIV_W-1:0]          wtot_q;
	logic signed [DIFF_W:0]    step_x_q, step_y_q, step_z_q;
	logic [DIV_W-1:0]          div_rem_q, div_quo_q, div_den_q;
	logic [SUMSQ_W-1:0]        sq_rad_q;
	logic [REM_W-1:0]          sq_rem_q;
	logic [ROOT_W-1:0]         sq_root_q;
	logic [MUL_P_W-1:0]        mul_s1;
	gmw_mul_kind_t             mul_kind_s1;
	logic [1:0]                mul_axis_s1;
	logic                      mul_neg_s1;
	gmw_result_t               out_q;

	// Control strobes from the output decoder.
	logic               ram_we, ram_re;
	logic               div_go, sq_go, mul_go;
	logic [DIV_W-1:0]   div_num, div_den;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	gmw_mul_kind_t      mul_kind;
	logic               out_load;

	logic [MEM_W-1:0]   ram_rdata;
	logic               full;
	logic               pt_last;

	assign full    = (count_q == CNT_W'(MAX_POINTS));
	assign pt_last = ((idx_q + CNT_W'(1)) == count_q);

	// Point memory holds x, y and z side by side.
	gmw_ram #(
		.WIDTH(MEM_W),
		.DEPTH(MAX_POINTS)
	) u_points (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[ADDR_W-1:0]),
		.wdata({point.coord_z, point.coord_y, point.coord_x}),
		.re   (ram_re),
		.raddr(idx_q[ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	logic signed [COORD_W-1:0] rd_x, rd_y, rd_z;
	assign rd_x = ram_rdata[COORD_W-1:0];
	assign rd_y = ram_rdata[2*COORD_W-1:COORD_W];
	assign rd_z = ram_rdata[3*COORD_W-1:2*COORD_W];

	// Centroid sums including the point just read.
	logic signed [DIV_W-1:0] sum_x_nxt, sum_y_nxt, sum_z_nxt;
	assign sum_x_nxt = sum_x_q + DIV_W'(rd_x);
	assign sum_y_nxt = sum_y_q + DIV_W'(rd_y);
	assign sum_z_nxt = sum_z_q + DIV_W'(rd_z);

	// Per-axis selection for the serial multiplier.
	logic [DIFF_W-1:0] mag_sel;
	always_comb begin
		case (axis_q)
			2'd0:    mag_sel = mag_x_q;
			2'd1:    mag_sel = mag_y_q;
			default: mag_sel = mag_z_q;
		endcase
	end

	// Serial restoring divider step.
	logic [DIV_W:0]   div_trial;
	logic             div_ge;
	logic [DIV_W-1:0] div_rem_n;
	assign div_trial = {div_rem_q, div_quo_q[DIV_W-1]};
	assign div_ge    = (div_trial >= {1'b0, div_den_q});
	assign div_rem_n = div_ge ? DIV_W'(div_trial - {1'b0, div_den_q}) : div_trial[DIV_W-1:0];

	// Digit-by-digit square root step.
	logic [REM_W-1:0] sq_sh, sq_trial;
	logic             sq_ge;
	assign sq_sh    = {sq_rem_q[REM_W-3:0], sq_rad_q[SUMSQ_W-1:SUMSQ_W-2]};
	assign sq_trial = {1'b0, sq_root_q, 2'b01};
	assign sq_ge    = (sq_sh >= sq_trial);

	// Accumulation of the registered partial product.
	logic [SUMSQ_W-1:0] sq_term, sumsq_nxt;
	logic [DIV_W-1:0]   w_term;
	always_comb begin
		case (mul_kind_s1)
			MK_SQ_HH: sq_term = SUMSQ_W'(mul_s1) << 50;
			MK_SQ_HL: sq_term = SUMSQ_W'(mul_s1) << 26;
			default:  sq_term = SUMSQ_W'(mul_s1);
		endcase
		w_term = (mul_kind_s1 == MK_W_HI) ? (DIV_W'(mul_s1) << 25) : DIV_W'(mul_s1);
		sumsq_nxt = sumsq_q + sq_term;
	end

	logic sq_mul, w_mul;
	assign sq_mul = mul_v_s1 && (mul_kind_s1 == MK_SQ_HH || mul_kind_s1 == MK_SQ_HL ||
		mul_kind_s1 == MK_SQ_LL);
	assign w_mul  = mul_v_s1 && (mul_kind_s1 == MK_W_LO || mul_kind_s1 == MK_W_HI);

	// Estimate update with saturation.
	logic signed [COORD_W+2:0] upd_x, upd_y, upd_z;
	assign upd_x = (COORD_W+3)'(est_x_q) + (COORD_W+3)'(step_x_q);
	assign upd_y = (COORD_W+3)'(est_y_q) + (COORD_W+3)'(step_y_q);
	assign upd_z = (COORD_W+3)'(est_z_q) + (COORD_W+3)'(step_z_q);

	function automatic logic signed [COORD_W-1:0] clamp48(input logic signed [COORD_W+2:0] v);
		if (v > (COORD_W+3)'(COORD_MAX_C)) begin
			clamp48 = COORD_MAX_C[COORD_W-1:0];
		end else if (v < (COORD_W+3)'(COORD_MIN_C)) begin
			clamp48 = COORD_MIN_C[COORD_W-1:0];
		end else begin
			clamp48 = v[COORD_W-1:0];
		end
	endfunction

	// Signed quotient from the unsigned divider result.
	logic signed [DIFF_W:0] quo_signed;
	logic                   ws_neg_sel;
	always_comb begin
		case (axis_q)
			2'd0:    ws_neg_sel = ws_x_q[DIV_W-1];
			2'd1:    ws_neg_sel = ws_y_q[DIV_W-1];
			default: ws_neg_sel = ws_z_q[DIV_W-1];
		endcase
		quo_signed = ws_neg_sel ? -$signed({1'b0, div_quo_q[DIFF_W-1:0]})
			: $signed({1'b0, div_quo_q[DIFF_W-1:0]});
	end

	logic signed [DIV_W-1:0] cen_sum_sel;
	always_comb begin
		case (axis_q)
			2'd0:    cen_sum_sel = sum_x_q;
			2'd1:    cen_sum_sel = sum_y_q;
			default: cen_sum_sel = sum_z_q;
		endcase
	end
	logic signed [COORD_W-1:0] cen_val;
	assign cen_val = cen_sum_sel[DIV_W-1] ? COORD_W'(-div_quo_q) : COORD_W'(div_quo_q);

	// Point minus estimate.
	logic signed [DIFF_W-1:0] dx, dy, dz;
	assign dx = DIFF_W'(rd_x) - DIFF_W'(est_x_q);
	assign dy = DIFF_W'(rd_y) - DIFF_W'(est_y_q);
	assign dz = DIFF_W'(rd_z) - DIFF_W'(est_z_q);

	logic div_done, sq_done;
	assign div_done = (div_cnt_q == 7'd0);
	assign sq_done  = (sq_cnt_q == 6'd0);

	logic skip_pt;
	assign skip_pt = (sq_root_q == '0) || (sq_root_q < ROOT_W'(degen_tol_q));

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (point_valid && point.last_point) begin
					state_d = ST_SUM_RD;
				end
			end
			ST_SUM_RD:  state_d = ST_SUM_ACC;
			ST_SUM_ACC: state_d = pt_last ? ST_CEN_DIV : ST_SUM_RD;
			ST_CEN_DIV: begin
				if (div_done && axis_q == 2'd2) begin
					state_d = ST_PASS_INIT;
				end
			end
			ST_PASS_INIT: state_d = (pass_q == max_iter_q) ? ST_OUT : ST_PT_RD;
			ST_PT_RD:     state_d = ST_PT_DIFF;
			ST_PT_DIFF:   state_d = ST_SQ;
			ST_SQ: begin
				if (axis_q == 2'd2 && part_q == 2'd2) begin
					state_d = ST_SQ_ACC;
				end
			end
			ST_SQ_ACC: state_d = ST_SQRT;
			ST_SQRT: begin
				if (sq_done) begin
					if (conv_mode_q) begin
						state_d = (sq_root_q < ROOT_W'(conv_tol_q)) ? ST_OUT : ST_PASS_INIT;
					end else if (!skip_pt) begin
						state_d = ST_WDIV;
					end else begin
						state_d = pt_last ? ST_PASS_END : ST_PT_RD;
					end
				end
			end
			ST_WDIV: begin
				if (div_done) begin
					state_d = ST_WMUL;
				end
			end
			ST_WMUL: begin
				if (axis_q == 2'd2 && part_q == 2'd1) begin
					state_d = ST_WMUL_ACC;
				end
			end
			ST_WMUL_ACC: state_d = pt_last ? ST_PASS_END : ST_PT_RD;
			ST_PASS_END: begin
				if (wtot_q < DIV_W'(degen_tol_q) || wtot_q == '0) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_STEP_DIV;
				end
			end
			ST_STEP_DIV: begin
				if (div_done && axis_q == 2'd2) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: state_d = ST_SQ;
			ST_OUT: begin
				if (!out_valid_q || !median_stall) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// Output decode: memory, divider, square root and multiplier strobes.
	always_comb begin
		point_stall = (state_q != ST_LOAD);
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		div_go   = 1'b0;
		div_num  = '0;
		div_den  = '0;
		sq_go    = 1'b0;
		mul_go   = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		mul_kind = MK_SQ_LL;
		out_load = 1'b0;
		case (state_q)
			ST_LOAD: ram_we = point_valid && !full;
			ST_SUM_RD, ST_PT_RD: ram_re = 1'b1;
			ST_SUM_ACC: begin
				if (pt_last) begin
					div_go  = 1'b1;
					div_num = abs64(sum_x_nxt);
					div_den = DIV_W'(count_q);
				end
			end
			ST_CEN_DIV: begin
				if (div_done && axis_q != 2'd2) begin
					div_go  = 1'b1;
					div_num = (axis_q == 2'd0) ? abs64(sum_y_q) : abs64(sum_z_q);
					div_den = DIV_W'(count_q);
				end
			end
			ST_SQ: begin
				mul_go = 1'b1;
				case (part_q)
					2'd0: begin
						mul_a    = MUL_A_W'(mag_sel[DIFF_W-1:MUL_B_W]);
						mul_b    = MUL_B_W'(mag_sel[DIFF_W-1:MUL_B_W]);
						mul_kind = MK_SQ_HH;
					end
					2'd1: begin
						mul_a    = MUL_A_W'(mag_sel[DIFF_W-1:MUL_B_W]);
						mul_b    = mag_sel[MUL_B_W-1:0];
						mul_kind = MK_SQ_HL;
					end
					default: begin
						mul_a    = MUL_A_W'(mag_sel[MUL_B_W-1:0]);
						mul_b    = mag_sel[MUL_B_W-1:0];
						mul_kind = MK_SQ_LL;
					end
				endcase
			end
			ST_SQ_ACC: sq_go = 1'b1;
			ST_SQRT: begin
				if (sq_done && !conv_mode_q && !skip_pt) begin
					div_go  = 1'b1;
					div_num = WEIGHT_ONE;
					div_den = DIV_W'(sq_root_q);
				end
			end
			ST_WMUL: begin
				mul_go = 1'b1;
				mul_a  = w_q;
				if (part_q == 2'd0) begin
					mul_b    = mag_sel[MUL_B_W-1:0];
					mul_kind = MK_W_LO;
				end else begin
					mul_b    = MUL_B_W'(mag_sel[DIFF_W-1:MUL_B_W]);
					mul_kind = MK_W_HI;
				end
			end
			ST_PASS_END: begin
				div_go  = 1'b1;
				div_num = abs64(ws_x_q);
				div_den = wtot_q;
			end
			ST_STEP_DIV: begin
				if (div_done && axis_q != 2'd2) begin
					div_go  = 1'b1;
					div_num = (axis_q == 2'd0) ? abs64(ws_y_q) : abs64(ws_z_q);
					div_den = wtot_q;
				end
			end
			ST_OUT: out_load = !out_valid_q || !median_stall;
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			max_iter_q  <= MAX_ITER_RST;
			conv_tol_q  <= CONV_TOL_RST;
			degen_tol_q <= DEGEN_TOL_RST;
			count_q     <= '0;
			idx_q       <= '0;
			dropped_q   <= 1'b0;
			pass_q      <= '0;
			conv_mode_q <= 1'b0;
			axis_q      <= '0;
			part_q      <= '0;
			div_cnt_q   <= '0;
			sq_cnt_q    <= '0;
			mul_v_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			mul_v_s1 <= mul_go;

			if (cfg_we) begin
				case (cfg_index)
					CFG_MAX_ITER:  max_iter_q  <= cfg_data[ITER_W-1:0];
					CFG_CONV_TOL:  conv_tol_q  <= cfg_data[TOL_W-1:0];
					CFG_DEGEN_TOL: degen_tol_q <= cfg_data[TOL_W-1:0];
					default: ;
				endcase
			end

			if (div_go) begin
				div_cnt_q <= 7'd64;
			end else if (!div_done) begin
				div_cnt_q <= div_cnt_q - 7'd1;
			end
			if (sq_go) begin
				sq_cnt_q <= 6'd50;
			end else if (!sq_done) begin
				sq_cnt_q <= sq_cnt_q - 6'd1;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (median_valid && !median_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_LOAD: begin
					if (point_valid) begin
						if (full) begin
							dropped_q <= 1'b1;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
						idx_q  <= '0;
						axis_q <= '0;
					end
				end
				ST_SUM_ACC: idx_q <= idx_q + CNT_W'(1);
				ST_CEN_DIV: begin
					if (div_done && axis_q != 2'd2) begin
						axis_q <= axis_q + 2'd1;
					end
					pass_q <= '0;
				end
				ST_PASS_INIT: idx_q <= '0;
				ST_PT_DIFF: begin
					axis_q      <= '0;
					part_q      <= '0;
					conv_mode_q <= 1'b0;
				end
				ST_SQ: begin
					if (part_q == 2'd2) begin
						part_q <= '0;
						axis_q <= axis_q + 2'd1;
					end else begin
						part_q <= part_q + 2'd1;
					end
				end
				ST_SQRT: begin
					if (sq_done && !conv_mode_q && skip_pt) begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				ST_WDIV: begin
					axis_q <= '0;
					part_q <= '0;
				end
				ST_WMUL: begin
					if (part_q == 2'd1) begin
						part_q <= '0;
						axis_q <= axis_q + 2'd1;
					end else begin
						part_q <= part_q + 2'd1;
					end
				end
				ST_WMUL_ACC: idx_q <= idx_q + CNT_W'(1);
				ST_PASS_END: axis_q <= '0;
				ST_STEP_DIV: begin
					if (div_done && axis_q != 2'd2) begin
						axis_q <= axis_q + 2'd1;
					end
				end
				ST_UPDATE: begin
					pass_q      <= pass_q + ITER_W'(1);
					conv_mode_q <= 1'b1;
					axis_q      <= '0;
					part_q      <= '0;
				end
				ST_OUT: begin
					if (out_load) begin
						count_q   <= '0;
						dropped_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		// Shared multiplier, one register after it.
		mul_s1      <= mul_a * mul_b;
		mul_kind_s1 <= mul_kind;
		mul_axis_s1 <= axis_q;
		case (axis_q)
			2'd0:    mul_neg_s1 <= neg_x_q;
			2'd1:    mul_neg_s1 <= neg_y_q;
			default: mul_neg_s1 <= neg_z_q;
		endcase

		if (sq_mul) begin
			sumsq_q <= sumsq_nxt;
		end
		if (w_mul) begin
			case (mul_axis_s1)
				2'd0:    ws_x_q <= mul_neg_s1 ? ws_x_q - w_term : ws_x_q + w_term;
				2'd1:    ws_y_q <= mul_neg_s1 ? ws_y_q - w_term : ws_y_q + w_term;
				default: ws_z_q <= mul_neg_s1 ? ws_z_q - w_term : ws_z_q + w_term;
			endcase
		end

		// Divider.
		if (div_go) begin
			div_rem_q <= '0;
			div_quo_q <= div_num;
			div_den_q <= div_den;
		end else if (!div_done) begin
			div_rem_q <= div_rem_n;
			div_quo_q <= {div_quo_q[DIV_W-2:0], div_ge};
		end

		// Square root.
		if (sq_go) begin
			sq_rad_q  <= sumsq_nxt;
			sq_rem_q  <= '0;
			sq_root_q <= '0;
		end else if (!sq_done) begin
			sq_rad_q  <= sq_rad_q << 2;
			sq_rem_q  <= sq_ge ? REM_W'(sq_sh - sq_trial) : sq_sh;
			sq_root_q <= {sq_root_q[ROOT_W-2:0], sq_ge};
		end

		case (state_q)
			ST_LOAD: begin
				sum_x_q <= '0;
				sum_y_q <= '0;
				sum_z_q <= '0;
			end
			ST_SUM_ACC: begin
				sum_x_q <= sum_x_nxt;
				sum_y_q <= sum_y_nxt;
				sum_z_q <= sum_z_nxt;
			end
			ST_CEN_DIV: begin
				if (div_done) begin
					case (axis_q)
						2'd0:    est_x_q <= cen_val;
						2'd1:    est_y_q <= cen_val;
						default: est_z_q <= cen_val;
					endcase
				end
			end
			ST_PASS_INIT: begin
				ws_x_q <= '0;
				ws_y_q <= '0;
				ws_z_q <= '0;
				wtot_q <= '0;
			end
			ST_PT_DIFF: begin
				neg_x_q <= dx[DIFF_W-1];
				neg_y_q <= dy[DIFF_W-1];
				neg_z_q <= dz[DIFF_W-1];
				mag_x_q <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
				mag_y_q <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
				mag_z_q <= dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
				sumsq_q <= '0;
			end
			ST_WDIV: begin
				if (div_done) begin
					w_q    <= div_quo_q[MUL_A_W-1:0];
					wtot_q <= wtot_q + div_quo_q;
				end
			end
			ST_STEP_DIV: begin
				if (div_done) begin
					case (axis_q)
						2'd0:    step_x_q <= quo_signed;
						2'd1:    step_y_q <= quo_signed;
						default: step_z_q <= quo_signed;
					endcase
				end
			end
			ST_UPDATE: begin
				est_x_q <= clamp48(upd_x);
				est_y_q <= clamp48(upd_y);
				est_z_q <= clamp48(upd_z);
				mag_x_q <= step_x_q[DIFF_W] ? DIFF_W'(-step_x_q) : DIFF_W'(step_x_q);
				mag_y_q <= step_y_q[DIFF_W] ? DIFF_W'(-step_y_q) : DIFF_W'(step_y_q);
				mag_z_q <= step_z_q[DIFF_W] ? DIFF_W'(-step_z_q) : DIFF_W'(step_z_q);
				sumsq_q <= '0;
			end
			default: ;
		endcase

		// Result register.
		if (out_load) begin
			out_q.median_x        <= (count_q == '0) ? '0 : est_x_q;
			out_q.median_y        <= (count_q == '0) ? '0 : est_y_q;
			out_q.median_z        <= (count_q == '0) ? '0 : est_z_q;
			out_q.iterations_done <= (count_q == '0) ? '0 : pass_q;
			out_q.set_empty       <= (count_q == '0);
			out_q.overflowed      <= dropped_q;
		end
	end

	assign median_valid = out_valid_q;
	assign median       = out_q;

endmodule

>>> test/gmw_median_checker.sv
// Checker for the geometric median block: predicts each median and compares it.
`timescale 1ns / 1ps

module gmw_median_checker #(
	parameter int MAX_POINTS = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 point_valid,
	input  logic                 point_stall,
	input  gmw_pkg::gmw_point_t  point,
	input  logic                 median_valid,
	input  logic                 median_stall,
	input  gmw_pkg::gmw_result_t median,
	input  logic                 cfg_we,
	input  logic [gmw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gmw_pkg::CFG_W-1:0]     cfg_data,
	output int unsigned          fail_count,
	output int unsigned          pending,
	output int unsigned          medians_seen
);
	import gmw_pkg::*;

	localparam longint COORD_TOP = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint COORD_BOT = -64'sh0000_8000_0000_0000;

	// Shadow copies of the registers and of the point set being loaded.
	logic [7:0]  iter_limit;
	logic [15:0] conv_tol;
	logic [15:0] degen_tol;
	longint      set_x[$];
	longint      set_y[$];
	longint      set_z[$];
	logic        set_dropped;
	gmw_result_t median_queue[$];

	function automatic logic [63:0] magnitude(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	// Floor of the Euclidean length of a vector given by its axis magnitudes.
	function automatic logic [63:0] length3(logic [63:0] ax, logic [63:0] ay, logic [63:0] az);
		logic [127:0] sumsq;
		logic [127:0] trial_sq;
		logic [63:0]  root;
		logic [63:0]  trial;
		sumsq = {64'd0, ax} * {64'd0, ax} + {64'd0, ay} * {64'd0, ay} + {64'd0, az} * {64'd0, az};
		root = 0;
		for (int k = 50; k >= 0; k--) begin
			trial = root | (64'd1 << k);
			trial_sq = {64'd0, trial} * {64'd0, trial};
			if (trial_sq <= sumsq)
				root = trial;
		end
		return root;
	endfunction

	function automatic longint step_of(longint num, logic [63:0] den);
		logic [63:0] q;
		q = magnitude(num) / den;
		return num < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint saturate48(longint v);
		if (v > COORD_TOP)
			return COORD_TOP;
		if (v < COORD_BOT)
			return COORD_BOT;
		return v;
	endfunction

	// Centroid start followed by weighted refinement passes.
	function automatic gmw_result_t solve_median();
		gmw_result_t res;
		longint      ex, ey, ez, sx, sy, sz, dx, dy, dz, stx, sty, stz;
		logic [63:0] span, wgt, wsum;
		logic [7:0]  passes;
		int          n;
		n = set_x.size();
		res = '0;
		res.overflowed = set_dropped;
		if (n == 0) begin
			res.set_empty = 1'b1;
			return res;
		end
		sx = 0;
		sy = 0;
		sz = 0;
		for (int i = 0; i < n; i++) begin
			sx += set_x[i];
			sy += set_y[i];
			sz += set_z[i];
		end
		ex = sx / longint'(n);
		ey = sy / longint'(n);
		ez = sz / longint'(n);
		passes = 0;
		for (int it = 0; it < iter_limit; it++) begin
			sx = 0;
			sy = 0;
			sz = 0;
			wsum = 0;
			for (int i = 0; i < n; i++) begin
				dx = set_x[i] - ex;
				dy = set_y[i] - ey;
				dz = set_z[i] - ez;
				span = length3(magnitude(dx), magnitude(dy), magnitude(dz));
				if (span == 0 || span < 64'(degen_tol))
					continue;
				wgt = (64'd1 << 32) / span;
				sx += dx < 0 ? -longint'(wgt * magnitude(dx)) : longint'(wgt * magnitude(dx));
				sy += dy < 0 ? -longint'(wgt * magnitude(dy)) : longint'(wgt * magnitude(dy));
				sz += dz < 0 ? -longint'(wgt * magnitude(dz)) : longint'(wgt * magnitude(dz));
				wsum += wgt;
			end
			// Too little total weight: stop without moving.
			if (wsum < 64'(degen_tol) || wsum == 0)
				break;
			stx = step_of(sx, wsum);
			sty = step_of(sy, wsum);
			stz = step_of(sz, wsum);
			ex = saturate48(ex + stx);
			ey = saturate48(ey + sty);
			ez = saturate48(ez + stz);
			passes++;
			if (length3(magnitude(stx), magnitude(sty), magnitude(stz)) < 64'(conv_tol))
				break;
		end
		res.median_x = ex[47:0];
		res.median_y = ey[47:0];
		res.median_z = ez[47:0];
		res.iterations_done = passes;
		return res;
	endfunction

	assign pending = median_queue.size();

	// Register writes and point transactions update the prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_limit <= MAX_ITER_RST;
			conv_tol <= CONV_TOL_RST;
			degen_tol <= DEGEN_TOL_RST;
			set_x.delete();
			set_y.delete();
			set_z.delete();
			set_dropped = 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MAX_ITER: iter_limit <= cfg_data[7:0];
					CFG_CONV_TOL: conv_tol <= cfg_data;
					CFG_DEGEN_TOL: degen_tol <= cfg_data;
					default: ;
				endcase
			end
			if (point_valid && !point_stall) begin
				if (set_x.size() < MAX_POINTS) begin
					set_x = {set_x, longint'(point.coord_x)};
					set_y = {set_y, longint'(point.coord_y)};
					set_z = {set_z, longint'(point.coord_z)};
				end else begin
					set_dropped = 1'b1;
				end
				if (point.last_point) begin
					median_queue = {median_queue, solve_median()};
					set_x.delete();
					set_y.delete();
					set_z.delete();
					set_dropped = 1'b0;
				end
			end
		end
	end

	// Each median transaction is compared with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		gmw_result_t want;
		if (!arst_n) begin
			fail_count <= 0;
			medians_seen <= 0;
		end else if (median_valid && !median_stall) begin
			medians_seen <= medians_seen + 1;
			if (median_queue.size() == 0) begin
				$error("median transaction with no prediction waiting");
				fail_count <= fail_count + 1;
			end else begin
				want = median_queue.pop_front();
				if (median !== want) begin
					fail_count <= fail_count + 1;
					if (median.median_x !== want.median_x)
						$error("median_x expected %0d got %0d", want.median_x, median.median_x);
					if (median.median_y !== want.median_y)
						$error("median_y expected %0d got %0d", want.median_y, median.median_y);
					if (median.median_z !== want.median_z)
						$error("median_z expected %0d got %0d", want.median_z, median.median_z);
					if (median.iterations_done !== want.iterations_done)
						$error("iterations_done expected %0d got %0d",
							want.iterations_done, median.iterations_done);
					if (median.set_empty !== want.set_empty)
						$error("set_empty expected %0d got %0d", want.set_empty, median.set_empty);
					if (median.overflowed !== want.overflowed)
						$error("overflowed expected %0d got %0d", want.overflowed, median.overflowed);
				end
			end
		end
	end

endmodule

>>> test/geometric_median_weiszfeld_top_tb.sv
// Testbench top: drives point sets and register writes into the median block.
`timescale 1ns / 1ps

module geometric_median_weiszfeld_top_tb;
	import gmw_pkg::*;

	localparam int MAX_POINTS = 1024;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
	localparam longint CYCLE_LIMIT = 40_000_000;
	localparam logic [47:0] C_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] C_MIN = 48'h8000_0000_0000;

	logic        clk;
	logic        arst_n;
	logic        point_valid;
	logic        point_stall;
	gmw_point_t  point;
	logic        median_valid;
	logic        median_stall;
	gmw_result_t median;
	logic        cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int unsigned fail_count;
	int unsigned pending;
	int unsigned medians_seen;
	int unsigned points_sent;
	int unsigned burst_left;
	int unsigned stall_left;
	int unsigned stall_mode;
	longint      cycles;

	geometric_median_weiszfeld_top #(.MAX_POINTS(MAX_POINTS)) DUT (
		.clk(clk), .arst_n(arst_n),
		.point_valid(point_valid), .point_stall(point_stall), .point(point),
		.median_valid(median_valid), .median_stall(median_stall), .median(median),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	gmw_median_checker #(.MAX_POINTS(MAX_POINTS)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.point_valid(point_valid), .point_stall(point_stall), .point(point),
		.median_valid(median_valid), .median_stall(median_stall), .median(median),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending), .medians_seen(medians_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit in case the block hangs.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("geometric_median_weiszfeld_top test failed");
			$finish;
		end
	end

	// Receiver stall pattern: runs of free flow, solid stall, random and alternating.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_left <= $urandom_range(1, 40);
			stall_mode <= $urandom_range(0, 3);
			median_stall <= 1'b0;
		end else begin
			stall_left <= stall_left - 1;
			case (stall_mode)
				0: median_stall <= 1'b0;
				1: median_stall <= 1'b1;
				2: median_stall <= 1'($urandom_range(0, 1));
				default: median_stall <= ~median_stall;
			endcase
		end
	end

	// Sends one point transaction; bursts end with a random gap.
	task automatic send_point(logic [47:0] x, logic [47:0] y, logic [47:0] z, logic last);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				point_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 10);
		end
		point_valid <= 1'b1;
		point <= '{coord_x: x, coord_y: y, coord_z: z, last_point: last};
		@(posedge clk);
		while (point_stall)
			@(posedge clk);
		burst_left--;
		points_sent++;
	endtask

	// Lets every outstanding median drain before touching the registers.
	task automatic drain();
		point_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_regs(logic [CFG_W-1:0] iters, logic [CFG_W-1:0] conv, logic [CFG_W-1:0] degen);
		drain();
		write_reg(CFG_MAX_ITER, iters);
		write_reg(CFG_CONV_TOL, conv);
		write_reg(CFG_DEGEN_TOL, degen);
	endtask

	function automatic logic [47:0] any48();
		return 48'({$urandom, $urandom});
	endfunction

	function automatic logic [47:0] near(logic [47:0] base, int unsigned spread);
		return base + 48'($signed($urandom_range(0, 2 * spread)) - $signed(spread));
	endfunction

	// One random set: clustered, scattered, near zero or with repeated points.
	task automatic random_set();
		int unsigned n, kind, spread;
		logic [47:0] cx, cy, cz, px, py, pz;
		n = $urandom_range(0, 9) == 0 ? $urandom_range(7, 12) : $urandom_range(1, 6);
		kind = $urandom_range(0, 3);
		spread = 1 << $urandom_range(0, 24);
		cx = any48();
		cy = any48();
		cz = any48();
		for (int i = 0; i < n; i++) begin
			case (kind)
				0: begin px = near(cx, spread); py = near(cy, spread); pz = near(cz, spread); end
				1: begin px = any48(); py = any48(); pz = any48(); end
				2: begin px = near(0, spread); py = near(0, spread); pz = near(0, spread); end
				default: begin
					if (i == 0 || $urandom_range(0, 1) == 0) begin
						px = near(cx, spread); py = near(cy, spread); pz = near(cz, spread);
					end
				end
			endcase
			send_point(px, py, pz, i == n - 1);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		point_valid = 1'b0;
		point = '0;
		median_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MAX_ITER;
		cfg_data = '0;
		stall_left = 0;
		stall_mode = 0;
		burst_left = 0;
		points_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sets at reset settings: extremes, coincident points, a triangle.
		send_point(C_MAX, C_MAX, C_MAX, 1'b1);
		send_point(C_MIN, C_MIN, C_MIN, 1'b1);
		send_point(C_MAX, C_MIN, C_MAX, 1'b0);
		send_point(C_MIN, C_MAX, C_MIN, 1'b1);
		send_point(48'd500, 48'd500, 48'd500, 1'b0);
		send_point(48'd500, 48'd500, 48'd500, 1'b0);
		send_point(48'd500, 48'd500, 48'd500, 1'b1);
		send_point(48'h10000, 0, 0, 1'b0);
		send_point(0, 48'h10000, 0, 1'b0);
		send_point(0, 0, 48'h10000, 1'b0);
		send_point(48'h10000, 0, 0, 1'b1);
		send_point(-48'sd1, 48'd1, 0, 1'b0);
		send_point(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 48'h1234_5678_9ABC, 1'b1);

		// No refinement at all: the centroid comes straight out.
		set_regs(0, 0, 0);
		send_point(48'd7, -48'sd9, 48'd3, 1'b0);
		send_point(-48'sd4, 48'd2, 48'd11, 1'b1);

		// Widest limits: full pass budget, zero tolerances, then the largest ones.
		set_regs(255, 0, 0);
		send_point(0, 0, 0, 1'b0);
		send_point(48'h40000, 0, 0, 1'b0);
		send_point(0, 48'h40000, 0, 1'b1);
		set_regs(255, 65535, 65535);
		send_point(0, 0, 0, 1'b0);
		send_point(48'd100, 48'd100, 0, 1'b0);
		send_point(48'h7_0000, 48'h9_0000, 48'h3_0000, 1'b1);

		// Writes to the spare index are ignored; upper data bits are masked off.
		drain();
		write_reg(CFG_SPARE_IDX, 16'hFFFF);
		write_reg(CFG_MAX_ITER, 16'hFF01);
		send_point(48'h1_0000, 48'h2_0000, 48'h3_0000, 1'b0);
		send_point(-48'sh1_0000, 48'h5_0000, 0, 1'b1);

		// Capacity overflow with the dropped point ending the set.
		for (int i = 0; i <= MAX_POINTS; i++)
			send_point(near(0, 1 << 20), near(0, 1 << 20), near(0, 1 << 20), i == MAX_POINTS);

		// Random phases, each with its own register setting.
		for (int ph = 0; ph < 8; ph++) begin
			set_regs(16'($urandom_range(1, 6)),
				$urandom_range(0, 2) == 0 ? 16'd0
					: ($urandom_range(0, 1) ? 16'd1 : 16'($urandom_range(0, 65535))),
				$urandom_range(0, 2) == 0 ? 16'd0
					: ($urandom_range(0, 1) ? 16'd1 : 16'($urandom_range(0, 65535))));
			for (int s = 0; s < 8; s++)
				random_set();
		end

		drain();
		repeat (200) @(posedge clk);
		$display("Covered %0d points and %0d medians over directed extremes,", points_sent,
			medians_seen);
		$display("a capacity overflow and eight random register settings.");
		if (fail_count == 0)
			$display("geometric_median_weiszfeld_top test passed");
		else
			$display("geometric_median_weiszfeld_top test failed");
		$finish;
	end

endmodule

>>> filelist.f
src/gmw_pkg.sv
src/gmw_ram.sv
src/geometric_median_weiszfeld_top.sv
test/gmw_median_checker.sv
test/geometric_median_weiszfeld_top_tb.sv
